[sv/sfd_pkg.sv]
// Shared constants and types for the stuffed frame deframer.
package sfd_pkg;

  // Default frame size limit; payload offsets stay below this value.
  localparam int MaxFrameBytes = 2048;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] RegStartCode  = 2'd0;
  localparam logic [1:0] RegEndCode    = 2'd1;
  localparam logic [1:0] RegEscapeCode = 2'd2;
  localparam logic [1:0] RegMinFrame   = 2'd3;

  // Register reset values.
  localparam logic [7:0]  StartCodeReset = 8'h02;
  localparam logic [7:0]  EndCodeReset   = 8'h03;
  localparam logic [7:0]  EscapeReset    = 8'h10;
  localparam logic [11:0] MinFrameReset  = 12'd21;

  // Final status codes.
  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StCheck       = 3'd1;
  localparam logic [2:0] StBadEscape   = 3'd2;
  localparam logic [2:0] StStrayStart  = 3'd3;
  localparam logic [2:0] StOverflow    = 3'd4;

  // Header bytes captured on the fly.
  localparam int LenHiOffset = 2;
  localparam int LenLoOffset = 3;
  localparam int ProtoOffset = 9;

  // Accepted protocol numbers.
  localparam logic [7:0] ProtoIcmp = 8'h01;
  localparam logic [7:0] ProtoTcp  = 8'h06;
  localparam logic [7:0] ProtoUdp  = 8'h11;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic        last;
    logic [10:0] offset;
    logic [7:0]  value;
  } result_t;

endpackage

[sv/stuffed_frame_deframer.sv]
// Top level of the stuffed frame deframer: unstuffing, header capture and result buffer.
//
// Raw serial bytes enter on the slave stream (s_t*), one byte per transfer. A start
// code opens a frame; inside it an escape code makes the following start, end or
// escape code literal. Every payload byte leaves on the master stream (m_t*) with
// its offset in the frame. At the end code, or when the frame is aborted by a bad
// escape, a stray start code or an overflow, one final status transfer is sent
// with m_tlast high and the frame length as offset. Bytes outside a frame and
// escape codes produce no output.
// One byte is taken every cycle while the skid register is empty, set by the
// single state update between the input and the output register. A two-entry
// output buffer (output register plus skid register) keeps the input open
// while one result waits; s_tready drops only while both hold a result, so a
// stalled receiver stalls the input once the skid register fills.
// Synchronous reset (rst) clears the frame state, empties the output buffer and
// loads the code registers with their defaults. The APB port writes the start,
// end and escape codes and the minimum frame length; write them only while idle.
module stuffed_frame_deframer #(
  parameter int MAX_FRAME_BYTES = sfd_pkg::MaxFrameBytes
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] byte_value, [18:8] byte_offset, [23:19] zero
  output logic        m_tlast,   // frame_end
  output logic [2:0]  m_tuser,   // [2:0] frame_status
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Byte counter holds offsets up to MAX_FRAME_BYTES-1.
  localparam int CntW = $clog2(MAX_FRAME_BYTES);
  localparam logic [CntW-1:0] LastOffset = CntW'(MAX_FRAME_BYTES - 1);

  // Configuration registers.
  logic [7:0]  start_code;
  logic [7:0]  end_code;
  logic [7:0]  escape_code;
  logic [11:0] min_frame_bytes;

  // Frame state.
  logic            in_frame, in_frame_next;
  logic            in_escape, in_escape_next;
  logic [CntW-1:0] byte_count, byte_count_next;
  logic [15:0]     captured_length, captured_length_next;
  logic [7:0]      captured_protocol, captured_protocol_next;

  // Output buffer.
  sfd_pkg::result_t out_data, skid_data, result;
  logic             skid_valid;
  logic             result_valid;

  logic s_fire, m_fire, cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign s_fire    = s_tvalid && s_tready;
  assign m_fire    = m_tvalid && m_tready;
  assign s_tready  = !skid_valid;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_code      <= sfd_pkg::StartCodeReset;
      end_code        <= sfd_pkg::EndCodeReset;
      escape_code     <= sfd_pkg::EscapeReset;
      min_frame_bytes <= sfd_pkg::MinFrameReset;
    end else if (cfg_write) begin
      case (paddr[3:2])
        sfd_pkg::RegStartCode:  start_code      <= pwdata[7:0];
        sfd_pkg::RegEndCode:    end_code        <= pwdata[7:0];
        sfd_pkg::RegEscapeCode: escape_code     <= pwdata[7:0];
        sfd_pkg::RegMinFrame:   min_frame_bytes <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[3:2])
      sfd_pkg::RegStartCode:  prdata = {24'd0, start_code};
      sfd_pkg::RegEndCode:    prdata = {24'd0, end_code};
      sfd_pkg::RegEscapeCode: prdata = {24'd0, escape_code};
      sfd_pkg::RegMinFrame:   prdata = {20'd0, min_frame_bytes};
      default:                prdata = 32'd0;
    endcase
  end

  // Byte classification and frame checks.
  logic        is_start, is_end, is_escape, is_literal;
  logic        proto_ok, frame_ok;
  logic        do_data, do_finish;
  logic [2:0]  finish_status;
  logic [11:0] count_ext;

  assign is_start   = s_tdata == start_code;
  assign is_end     = s_tdata == end_code;
  assign is_escape  = s_tdata == escape_code;
  assign is_literal = is_start || is_end || is_escape;
  assign count_ext  = 12'(byte_count);
  assign proto_ok   = captured_protocol == sfd_pkg::ProtoIcmp ||
                      captured_protocol == sfd_pkg::ProtoTcp  ||
                      captured_protocol == sfd_pkg::ProtoUdp;
  assign frame_ok   = count_ext >= min_frame_bytes && proto_ok &&
                      {4'd0, count_ext} == captured_length;

  // Decide what the incoming byte does. The counter never passes the last
  // offset, so an end code cannot see an overflowed count.
  always_comb begin
    do_data        = 1'b0;
    do_finish      = 1'b0;
    finish_status  = sfd_pkg::StOk;
    in_frame_next  = in_frame;
    in_escape_next = in_escape;
    if (!in_frame) begin
      if (is_start) begin
        in_frame_next  = 1'b1;
        in_escape_next = 1'b0;
      end
    end else if (in_escape) begin
      in_escape_next = 1'b0;
      if (is_literal) begin
        do_data = 1'b1;
      end else begin
        do_finish     = 1'b1;
        finish_status = sfd_pkg::StBadEscape;
      end
    end else if (is_start) begin
      do_finish     = 1'b1;
      finish_status = sfd_pkg::StStrayStart;
    end else if (is_end) begin
      do_finish     = 1'b1;
      finish_status = frame_ok ? sfd_pkg::StOk : sfd_pkg::StCheck;
    end else if (is_escape) begin
      in_escape_next = 1'b1;
    end else begin
      do_data = 1'b1;
    end

    // A payload byte that would land on the last offset aborts the frame.
    if (do_data && byte_count >= LastOffset) begin
      do_data       = 1'b0;
      do_finish     = 1'b1;
      finish_status = sfd_pkg::StOverflow;
    end
    if (do_finish) begin
      in_frame_next  = 1'b0;
      in_escape_next = 1'b0;
    end
  end

  // Counter, header captures and the result item.
  always_comb begin
    byte_count_next        = byte_count;
    captured_length_next   = captured_length;
    captured_protocol_next = captured_protocol;
    if (!in_frame && is_start) begin
      byte_count_next        = '0;
      captured_length_next   = 16'd0;
      captured_protocol_next = 8'd0;
    end
    if (do_data) begin
      byte_count_next = byte_count + CntW'(1);
      if (byte_count == CntW'(sfd_pkg::LenHiOffset)) begin
        captured_length_next[15:8] = s_tdata;
      end else if (byte_count == CntW'(sfd_pkg::LenLoOffset)) begin
        captured_length_next[7:0] = s_tdata;
      end else if (byte_count == CntW'(sfd_pkg::ProtoOffset)) begin
        captured_protocol_next = s_tdata;
      end
    end

    result_valid  = do_data || do_finish;
    result.value  = do_data ? s_tdata : 8'd0;
    result.offset = count_ext[10:0];
    result.last   = do_finish;
    result.status = do_finish ? finish_status : sfd_pkg::StOk;
  end

  // Frame state registers, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame          <= 1'b0;
      in_escape         <= 1'b0;
      byte_count        <= '0;
      captured_length   <= 16'd0;
      captured_protocol <= 8'd0;
    end else if (s_fire) begin
      in_frame          <= in_frame_next;
      in_escape         <= in_escape_next;
      byte_count        <= byte_count_next;
      captured_length   <= captured_length_next;
      captured_protocol <= captured_protocol_next;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (s_fire && result_valid) begin
      if (!m_tvalid || m_fire) begin
        out_data <= result;
        m_tvalid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (m_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'd0, out_data.offset, out_data.value};
  assign m_tlast = out_data.last;
  assign m_tuser = out_data.status;

endmodule

[sim/tb.sv]
// Self-checking testbench for the stuffed frame deframer: directed table, then random frames.
module tb;

  localparam int FrameLimit  = sfd_pkg::MaxFrameBytes;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 300000;
  localparam int PhaseItems  = 50;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    RowPredict,
    RowNoResult,
    RowTyped,
    RowSetMin
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [11:0]      arg;
    sfd_pkg::result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the configuration and frame state.
  logic [7:0]  cfg_start;
  logic [7:0]  cfg_end;
  logic [7:0]  cfg_escape;
  logic [11:0] cfg_min;
  logic        fr_open;
  logic        fr_escaped;
  logic [11:0] fr_count;
  logic [15:0] fr_len;
  logic [7:0]  fr_proto;

  sfd_pkg::result_t pending_results [$];
  stim_row_t        directed_rows [$];
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               bytes_sent     = 0;
  int               fail_count     = 0;
  int               cycle_count    = 0;

  stuffed_frame_deframer #(.MAX_FRAME_BYTES(FrameLimit)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver stalls at the rate of the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each output transfer with the oldest pending result.
  always @(posedge clk) begin : check_output
    sfd_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: value %h offset %0d last %b status %0d",
                 $time, m_tdata[7:0], m_tdata[18:8], m_tlast, m_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.value || m_tdata[18:8] !== want.offset ||
            m_tlast !== want.last || m_tuser !== want.status) begin
          $display("%0t: mismatch: expected value %h offset %0d last %b status %0d",
                   $time, want.value, want.offset, want.last, want.status);
          $display("%0t:           actual value %h offset %0d last %b status %0d",
                   $time, m_tdata[7:0], m_tdata[18:8], m_tlast, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // Frame end: clears the frame flags and reports the byte count.
  function automatic sfd_pkg::result_t close_frame(input logic [2:0] status);
    sfd_pkg::result_t r;
    fr_open    = 1'b0;
    fr_escaped = 1'b0;
    r.value    = 8'h00;
    r.offset   = fr_count[10:0];
    r.last     = 1'b1;
    r.status   = status;
    return r;
  endfunction

  // Payload byte: capture header fields, or end the frame when it is full.
  function automatic sfd_pkg::result_t take_payload(input logic [7:0] b);
    sfd_pkg::result_t r;
    if (int'(fr_count) + 1 >= FrameLimit) return close_frame(sfd_pkg::StOverflow);
    if (int'(fr_count) == sfd_pkg::LenHiOffset) fr_len[15:8] = b;
    else if (int'(fr_count) == sfd_pkg::LenLoOffset) fr_len[7:0] = b;
    else if (int'(fr_count) == sfd_pkg::ProtoOffset) fr_proto = b;
    r.value  = b;
    r.offset = fr_count[10:0];
    r.last   = 1'b0;
    r.status = sfd_pkg::StOk;
    fr_count = fr_count + 12'd1;
    return r;
  endfunction

  // Unstuffing predictor: returns 1 when the byte produces a result.
  function automatic bit deframe_step(input logic [7:0] b, output sfd_pkg::result_t r);
    logic proto_ok;
    r = '0;
    if (!fr_open) begin
      if (b == cfg_start) begin
        fr_open    = 1'b1;
        fr_escaped = 1'b0;
        fr_count   = '0;
        fr_len     = '0;
        fr_proto   = '0;
      end
      return 1'b0;
    end
    if (fr_escaped) begin
      fr_escaped = 1'b0;
      if (b == cfg_start || b == cfg_end || b == cfg_escape) r = take_payload(b);
      else r = close_frame(sfd_pkg::StBadEscape);
      return 1'b1;
    end
    if (b == cfg_start) begin
      r = close_frame(sfd_pkg::StStrayStart);
      return 1'b1;
    end
    if (b == cfg_end) begin
      proto_ok = (fr_proto == sfd_pkg::ProtoIcmp) || (fr_proto == sfd_pkg::ProtoTcp) ||
                 (fr_proto == sfd_pkg::ProtoUdp);
      if (int'(fr_count) >= FrameLimit) r = close_frame(sfd_pkg::StOverflow);
      else if (fr_count >= cfg_min && proto_ok && {4'b0, fr_count} == fr_len)
        r = close_frame(sfd_pkg::StOk);
      else r = close_frame(sfd_pkg::StCheck);
      return 1'b1;
    end
    if (b == cfg_escape) begin
      fr_escaped = 1'b1;
      return 1'b0;
    end
    r = take_payload(b);
    return 1'b1;
  endfunction

  // Send one byte; the expectation is queued at the accepting edge.
  task automatic push_byte(input logic [7:0] b, input row_kind_t kind = RowPredict,
                           input sfd_pkg::result_t want = '0);
    sfd_pkg::result_t r;
    bit               got;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    got = deframe_step(b, r);
    bytes_sent++;
    if (kind == RowTyped) pending_results.push_back(want);
    else if (kind == RowPredict && got) pending_results.push_back(r);
  endtask

  // Stop sending and wait until every pending result has arrived.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write over the configuration port, taken only while idle.
  task automatic cfg_write(input logic [1:0] idx, input logic [11:0] val);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {20'b0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sfd_pkg::RegStartCode:  cfg_start  = val[7:0];
      sfd_pkg::RegEndCode:    cfg_end    = val[7:0];
      sfd_pkg::RegEscapeCode: cfg_escape = val[7:0];
      sfd_pkg::RegMinFrame:   cfg_min    = val;
      default: ;
    endcase
  endtask

  // One stuffed frame with a plausible header and a random ending.
  task automatic send_frame(input int len);
    logic [15:0] hdr_len;
    logic [7:0]  b;
    hdr_len = ($urandom_range(4) != 0) ? 16'(len) : 16'($urandom);
    push_byte(cfg_start);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == sfd_pkg::LenHiOffset) b = hdr_len[15:8];
      else if (i == sfd_pkg::LenLoOffset) b = hdr_len[7:0];
      else if (i == sfd_pkg::ProtoOffset) begin
        case ($urandom_range(3))
          0: b = sfd_pkg::ProtoIcmp;
          1: b = sfd_pkg::ProtoTcp;
          2: b = sfd_pkg::ProtoUdp;
          default: ;
        endcase
      end
      // A rare raw byte corrupts the frame.
      if ($urandom_range(49) == 0) push_byte(8'($urandom));
      if (b == cfg_start || b == cfg_end || b == cfg_escape) push_byte(cfg_escape);
      push_byte(b);
    end
    case ($urandom_range(9))
      7: begin
        push_byte(cfg_escape);
        do b = 8'($urandom); while (b == cfg_start || b == cfg_end || b == cfg_escape);
        push_byte(b);
      end
      8: push_byte(cfg_start);
      9: ;
      default: push_byte(cfg_end);
    endcase
    repeat ($urandom_range(2)) push_byte(8'($urandom));
  endtask

  // Directed table row.
  function automatic void add_row(input row_kind_t kind, input logic [11:0] arg,
                                  input logic [7:0] value = 8'h00,
                                  input logic [10:0] offset = 11'd0,
                                  input logic last = 1'b0,
                                  input logic [2:0] status = sfd_pkg::StOk);
    stim_row_t row;
    row.kind        = kind;
    row.arg         = arg;
    row.want.value  = value;
    row.want.offset = offset;
    row.want.last   = last;
    row.want.status = status;
    directed_rows.push_back(row);
  endfunction

  initial begin
    int          len;
    int          base;
    bit          paused;
    logic [7:0]  sc;
    logic [7:0]  ec;
    logic [7:0]  xc;
    logic [11:0] mn;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    m_tready = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cfg_start  = sfd_pkg::StartCodeReset;
    cfg_end    = sfd_pkg::EndCodeReset;
    cfg_escape = sfd_pkg::EscapeReset;
    cfg_min    = sfd_pkg::MinFrameReset;
    fr_open    = 1'b0;
    fr_escaped = 1'b0;
    fr_count   = '0;
    fr_len     = '0;
    fr_proto   = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset codes: bytes outside a frame, escapes,
    // a short frame, a bad escape and a stray start.
    add_row(RowNoResult, 12'h000);
    add_row(RowNoResult, 12'h0FF);
    add_row(RowNoResult, {4'd0, sfd_pkg::StartCodeReset});
    add_row(RowTyped, 12'h0FF, 8'hFF, 11'd0);
    add_row(RowNoResult, {4'd0, sfd_pkg::EscapeReset});
    add_row(RowTyped, {4'd0, sfd_pkg::StartCodeReset}, sfd_pkg::StartCodeReset, 11'd1);
    add_row(RowNoResult, {4'd0, sfd_pkg::EscapeReset});
    add_row(RowTyped, {4'd0, sfd_pkg::EscapeReset}, sfd_pkg::EscapeReset, 11'd2);
    add_row(RowTyped, {4'd0, sfd_pkg::EndCodeReset}, 8'h00, 11'd3, 1'b1, sfd_pkg::StCheck);
    add_row(RowNoResult, {4'd0, sfd_pkg::StartCodeReset});
    add_row(RowNoResult, {4'd0, sfd_pkg::EscapeReset});
    add_row(RowTyped, 12'h055, 8'h00, 11'd0, 1'b1, sfd_pkg::StBadEscape);
    add_row(RowNoResult, {4'd0, sfd_pkg::StartCodeReset});
    add_row(RowPredict, 12'h041);
    add_row(RowTyped, {4'd0, sfd_pkg::StartCodeReset}, 8'h00, 11'd1, 1'b1,
            sfd_pkg::StStrayStart);
    add_row(RowNoResult, {4'd0, sfd_pkg::EndCodeReset});
    // A minimal well-formed frame that passes every check.
    add_row(RowSetMin, 12'd10);
    add_row(RowNoResult, {4'd0, sfd_pkg::StartCodeReset});
    add_row(RowPredict, 12'h045);
    add_row(RowPredict, 12'h000);
    add_row(RowPredict, 12'h000);
    add_row(RowPredict, 12'h00A);
    add_row(RowPredict, 12'h000);
    add_row(RowPredict, 12'h000);
    add_row(RowPredict, 12'h000);
    add_row(RowPredict, 12'h000);
    add_row(RowPredict, 12'h040);
    add_row(RowPredict, {4'd0, sfd_pkg::ProtoTcp});
    add_row(RowTyped, {4'd0, sfd_pkg::EndCodeReset}, 8'h00, 11'd10, 1'b1, sfd_pkg::StOk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowSetMin) begin
        cfg_write(sfd_pkg::RegMinFrame, directed_rows[i].arg);
      end else begin
        push_byte(directed_rows[i].arg[7:0], directed_rows[i].kind, directed_rows[i].want);
      end
    end

    // Random phases; the codes and the idle pattern are set per phase.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      sc = 8'($urandom);
      ec = 8'($urandom);
      xc = 8'($urandom);
      mn = 12'($urandom_range(30, 1));
      case (p)
        0: begin
          sc = sfd_pkg::StartCodeReset;
          ec = sfd_pkg::EndCodeReset;
          xc = sfd_pkg::EscapeReset;
          mn = sfd_pkg::MinFrameReset;
        end
        1: mn = 12'd1;
        2: begin sc = 8'h00; ec = 8'hFF; xc = 8'($urandom_range(254, 1)); mn = 12'd2048; end
        // Codes that coincide are matched as start, then end, then escape.
        3: begin ec = sc; xc = sc; end
        4: ec = sc;
        5: xc = ec;
        6: xc = sc;
        default: mn = sfd_pkg::MinFrameReset;
      endcase
      cfg_write(sfd_pkg::RegStartCode, {4'b0, sc});
      cfg_write(sfd_pkg::RegEndCode, {4'b0, ec});
      cfg_write(sfd_pkg::RegEscapeCode, {4'b0, xc});
      cfg_write(sfd_pkg::RegMinFrame, mn);

      // Long frames: one just fits, one overflows.
      if (p == 1) begin
        send_frame(FrameLimit - 1);
        send_frame(FrameLimit + $urandom_range(16));
      end

      base   = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - base < PhaseItems) begin
        if (!paused && bytes_sent - base >= PhaseItems / 2) begin
          settle();
          paused = 1'b1;
        end
        case ($urandom_range(3))
          0: len = (cfg_min <= 40) ? int'(cfg_min) : $urandom_range(30);
          1: len = (cfg_min <= 40) ? int'(cfg_min) - 1 : $urandom_range(30);
          default: len = $urandom_range(30);
        endcase
        send_frame(len);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
